// ===== hw/rtl/itt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itt_pkg
// Shared types and constants of the id translation table.
// ----------------------------------------------------------------------------
package itt_pkg;

  localparam int unsigned NUM_TABLES      = 3;
  localparam int unsigned TABLE_DEPTH_DEF = 128;
  localparam int unsigned ID_W            = 32;
  localparam int unsigned FRESH_W         = 31;

  localparam logic [ID_W-1:0] NONE_ID = '1;

  localparam logic [1:0] K_CLEAR  = 2'd0;
  localparam logic [1:0] K_LOOKUP = 2'd1;
  localparam logic [1:0] K_SET    = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  localparam logic [1:0] T_NONE = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DISP,
    S_SCAN,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0] mapped;
    logic            hit;
    logic [1:0]      status;
  } result_t;

  typedef struct packed {
    logic    load;
    result_t res;
  } res_msg_t;

endpackage

// ===== hw/rtl/itt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module itt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 384,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/itt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itt_ctrl
// Sequencer: decodes a word, scans the selected table through the RAM
// read port, appends pairs and keeps the per-table entry counts.
// ----------------------------------------------------------------------------
module itt_ctrl import itt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned ADDR_W      = $clog2(NUM_TABLES * TABLE_DEPTH),
  parameter int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           kind,
  input  logic [1:0]           table_select,
  input  logic [ID_W-1:0]      given_id,
  input  logic [ID_W-1:0]      old_key,
  input  logic [FRESH_W-1:0]   fresh_id,
  input  logic                 slot_free,
  output res_msg_t             msg,
  output logic                 ram_we,
  output logic [ADDR_W-1:0]    ram_waddr,
  output logic [2*ID_W-1:0]    ram_wdata,
  output logic                 ram_re,
  output logic [ADDR_W-1:0]    ram_raddr,
  input  logic [2*ID_W-1:0]    ram_rdata
);

  localparam logic [ADDR_W-1:0] BASE1 = ADDR_W'(TABLE_DEPTH);
  localparam logic [ADDR_W-1:0] BASE2 = ADDR_W'(2 * TABLE_DEPTH);
  localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(TABLE_DEPTH);

  state_t state, state_next;

  logic [CNT_W-1:0] counts [NUM_TABLES];
  logic [CNT_W-1:0] idx;
  logic             pend;

  logic [1:0]         kind_q, tsel_q;
  logic [ID_W-1:0]    given_q, oldk_q;
  logic [FRESH_W-1:0] fresh_q;

  result_t          fin, fin_d;
  logic             act_app, act_app_d, act_clr, act_clr_d;
  logic [2*ID_W-1:0] act_pair, act_pair_d;

  logic             take, t_ok, go_scan, cmp_hit, scan_done, fin_load, fin_fire;
  logic [CNT_W-1:0]  cur_cnt;
  logic [ADDR_W-1:0] base;
  logic [ID_W-1:0]   fresh_ext;

  assign take      = in_valid && in_ready;
  assign t_ok      = (tsel_q != T_NONE);
  assign cur_cnt   = t_ok ? counts[tsel_q] : '0;
  assign fresh_ext = {1'b0, fresh_q};
  assign cmp_hit   = pend && (ram_rdata[2*ID_W-1:ID_W] == given_q);
  assign scan_done = cmp_hit || (idx == cur_cnt);
  assign fin_fire  = (state == S_FIN) && slot_free;

  always_comb begin
    unique case (tsel_q)
      2'd1:    base = BASE1;
      2'd2:    base = BASE2;
      default: base = '0;
    endcase
  end

  // result and pending action
  always_comb begin
    fin_d      = '{mapped: NONE_ID, hit: 1'b0, status: ST_OK};
    act_app_d  = 1'b0;
    act_clr_d  = 1'b0;
    act_pair_d = {oldk_q, given_q};
    go_scan    = 1'b0;
    if (state == S_DISP) begin
      unique case (kind_q)
        K_CLEAR: begin
          act_clr_d = 1'b1;
        end
        K_LOOKUP: begin
          if (given_q == NONE_ID || !t_ok) begin
            fin_d.status = ST_IGNORED;
          end else begin
            go_scan = 1'b1;
          end
        end
        K_SET: begin
          if (oldk_q == NONE_ID || given_q == NONE_ID || !t_ok) begin
            fin_d.status = ST_IGNORED;
          end else if (cur_cnt == FULL_CNT) begin
            fin_d.status = ST_FULL;
          end else begin
            act_app_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else begin
      act_pair_d = {given_q, fresh_ext};
      if (cmp_hit) begin
        fin_d.mapped = ram_rdata[ID_W-1:0];
        fin_d.hit    = 1'b1;
      end else begin
        fin_d.mapped = fresh_ext;
        if (cur_cnt == FULL_CNT) begin
          fin_d.status = ST_FULL;
        end else begin
          act_app_d = 1'b1;
        end
      end
    end
  end

  assign fin_load = ((state == S_DISP) && !go_scan) || ((state == S_SCAN) && scan_done);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (take) state_next = S_DISP;
      S_DISP: state_next = go_scan ? S_SCAN : S_FIN;
      S_SCAN: if (scan_done) state_next = S_FIN;
      S_FIN:  if (slot_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == S_IDLE);
    ram_re    = (state == S_SCAN) && !cmp_hit && (idx != cur_cnt);
    ram_raddr = base + ADDR_W'(idx);
    ram_we    = fin_fire && act_app;
    ram_waddr = base + ADDR_W'(cur_cnt);
    ram_wdata = act_pair;
    msg.load  = fin_fire;
    msg.res   = fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pend   <= 1'b0;
      counts <= '{default: '0};
    end else begin
      state <= state_next;
      pend  <= ram_re;
      if (fin_fire && act_clr) begin
        counts <= '{default: '0};
      end else if (fin_fire && act_app) begin
        counts[tsel_q] <= cur_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind_q  <= kind;
      tsel_q  <= table_select;
      given_q <= given_id;
      oldk_q  <= old_key;
      fresh_q <= fresh_id;
    end
    if (state == S_DISP) begin
      idx <= '0;
    end else if (ram_re) begin
      idx <= idx + 1'b1;
    end
    if (fin_load) begin
      fin      <= fin_d;
      act_app  <= act_app_d;
      act_clr  <= act_clr_d;
      act_pair <= act_pair_d;
    end
  end

endmodule

// ===== hw/rtl/id_translation_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_translation_table_top
// Three old-to-new id translation tables with lookup-or-insert, set and
// clear, held in one pair RAM with a registered result stage.
// ----------------------------------------------------------------------------
// channel | handshake           | payload
// in      | in_valid / in_ready | kind, table_select, given_id, old_key, fresh_id
// out     | out_valid/out_ready | mapped_id, hit, status
//
// Clear, set and ignored words go through the dispatch and finish states.
// A lookup reads one entry per cycle from the RAM read port: a miss scans
// every entry of the table, up to TABLE_DEPTH; a hit on entry k ends early.
// One word is in work at a time; a new word is taken once the result has
// moved into the output register. Reset clears the counts, no RAM sweep.
// ----------------------------------------------------------------------------
module id_translation_table_top import itt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                kind,
  input  logic [1:0]                table_select,
  input  logic signed [ID_W-1:0]    given_id,
  input  logic signed [ID_W-1:0]    old_key,
  input  logic [FRESH_W-1:0]        fresh_id,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [ID_W-1:0]    mapped_id,
  output logic                      hit,
  output logic [1:0]                status
);

  localparam int unsigned RAM_DEPTH = NUM_TABLES * TABLE_DEPTH;
  localparam int unsigned ADDR_W    = $clog2(RAM_DEPTH);
  localparam int unsigned CNT_W     = $clog2(TABLE_DEPTH + 1);

  res_msg_t             msg;
  logic                 slot_free;
  logic                 ram_we, ram_re;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [2*ID_W-1:0]    ram_wdata, ram_rdata;

  assign slot_free = !out_valid || out_ready;

  itt_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .table_select (table_select),
    .given_id     (given_id),
    .old_key      (old_key),
    .fresh_id     (fresh_id),
    .slot_free    (slot_free),
    .msg          (msg),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  itt_ram #(
    .WIDTH (2 * ID_W),
    .DEPTH (RAM_DEPTH),
    .AW    (ADDR_W)
  ) u_pair_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (msg.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.load) begin
      mapped_id <= msg.res.mapped;
      hit       <= msg.res.hit;
      status    <= msg.res.status;
    end
  end

`ifndef SYNTHESIS
  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> status == ST_OK && mapped_id != NONE_ID)
    else $error("hit word carries bad status or none id");

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one is in work");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    msg.load |-> slot_free)
    else $error("result loaded over an untaken word");
`endif

endmodule
